// ===== rtl/css_tok_pkg.sv =====
// ---------------------------------------------------------------------------
// css_tok_pkg
// Shared types, codes and helpers of the CSS token scanner.
// ---------------------------------------------------------------------------
`default_nettype none

package css_tok_pkg;

	localparam int POS_BITS = 16;
	localparam int Q_DEPTH  = 4;
	localparam int Q_AW     = $clog2(Q_DEPTH);

	localparam logic [3:0] K_LBRACE    = 4'd0;
	localparam logic [3:0] K_RBRACE    = 4'd1;
	localparam logic [3:0] K_COLON     = 4'd2;
	localparam logic [3:0] K_SEMICOLON = 4'd3;
	localparam logic [3:0] K_HASH      = 4'd4;
	localparam logic [3:0] K_DOT       = 4'd5;
	localparam logic [3:0] K_COMMA     = 4'd6;
	localparam logic [3:0] K_NUMBER    = 4'd7;
	localparam logic [3:0] K_UNIT      = 4'd8;
	localparam logic [3:0] K_IDENT     = 4'd9;
	localparam logic [3:0] K_STRING    = 4'd10;
	localparam logic [3:0] K_EOF       = 4'd11;
	localparam logic [3:0] K_ERROR     = 4'd12;

	localparam logic [7:0] CH_LBRACE  = 8'h7b;
	localparam logic [7:0] CH_RBRACE  = 8'h7d;
	localparam logic [7:0] CH_COLON   = 8'h3a;
	localparam logic [7:0] CH_SEMI    = 8'h3b;
	localparam logic [7:0] CH_HASH    = 8'h23;
	localparam logic [7:0] CH_DOT     = 8'h2e;
	localparam logic [7:0] CH_COMMA   = 8'h2c;
	localparam logic [7:0] CH_MINUS   = 8'h2d;
	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_UNDER   = 8'h5f;
	localparam logic [7:0] CH_NEWLINE = 8'h0a;
	localparam logic [7:0] CH_QUOTE   = 8'h22;
	localparam logic [7:0] CH_SPACE   = 8'h20;

	typedef logic [POS_BITS-1:0] pos_t;

	typedef struct packed {
		logic [3:0] kind;
		logic       has_text;
		logic [7:0] text_byte;
		logic       done;
		pos_t       row;
		pos_t       col;
		logic       last;
	} res_t;

	// up to two results caused by one input item
	typedef struct packed {
		logic two;
		res_t r0;
		res_t r1;
	} pair_t;

	function automatic res_t make_res(logic [3:0] kind, logic has, logic [7:0] b,
			logic done, pos_t row, pos_t col);
		res_t r;
		r.kind      = kind;
		r.has_text  = has;
		r.text_byte = has ? b : 8'd0;
		r.done      = done;
		r.row       = row;
		r.col       = col;
		r.last      = 1'b0;
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/css_token_scanner_unit.sv =====
// ---------------------------------------------------------------------------
// css_token_scanner_unit
// Streaming CSS tokenizer: bytes in, token results out, a queue in between.
// ---------------------------------------------------------------------------
// the results of a byte are written into the queue when the byte is taken
// throughput: one byte per cycle while full is low; each byte gives up to two
//   results, handed out one per pop cycle from the non-empty four-pair queue
// full rises only when that queue holds four pairs
// reset: asynchronous, scanner idle at row 1 column 1, queue empty
`default_nettype none

module css_token_scanner_unit import css_tok_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	output logic                     full,
	input  wire logic                kind,
	input  wire logic [7:0]          char_byte,
	output logic                     empty,
	input  wire logic                pop,
	output logic [3:0]               token_kind,
	output logic                     has_text,
	output logic [7:0]               text_byte,
	output logic                     token_done,
	output logic [POS_BITS-1:0]      start_row,
	output logic [POS_BITS-1:0]      start_col,
	output logic                     last
);

	logic  accept, q_push, q_pop, q_full, q_empty;
	pair_t q_in, q_head;
	res_t  res;

	assign full   = q_full;
	assign accept = push && !q_full;

	css_tok_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.kind      (kind),
		.char_byte (char_byte),
		.q_push    (q_push),
		.q_data    (q_in)
	);

	css_tok_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_push),
		.wr_data (q_in),
		.rd_en   (q_pop),
		.full    (q_full),
		.empty   (q_empty),
		.rd_data (q_head)
	);

	css_tok_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_head  (q_head),
		.pop     (pop),
		.q_pop   (q_pop),
		.empty   (empty),
		.res     (res)
	);

	assign token_kind = res.kind;
	assign has_text   = res.has_text;
	assign text_byte  = res.text_byte;
	assign token_done = res.done;
	assign start_row  = res.row;
	assign start_col  = res.col;
	assign last       = res.last;

	a_push_fills: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |=> !q_empty)
		else $error("queue empty after a write");

	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		(!q_empty && q_head.two) |-> !q_head.r0.last)
		else $error("first of two results marked last");

	a_rest_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !empty && !last) |=> !empty)
		else $error("results of one item split apart");

	a_eof_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && (token_kind == K_EOF)) |-> (last && token_done && !has_text))
		else $error("eof result malformed");

endmodule

`default_nettype wire

// ===== rtl/css_tok_front.sv =====
// ---------------------------------------------------------------------------
// css_tok_front
// Classifies each byte, keeps the scan mode and positions, forms results.
// ---------------------------------------------------------------------------
`default_nettype none

module css_tok_front import css_tok_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       accept,
	input  wire logic       kind,
	input  wire logic [7:0] char_byte,
	output logic            q_push,
	output pair_t           q_data
);

	typedef enum logic [2:0] {
		M_IDLE, M_MINUS, M_NUMBER, M_UNIT, M_IDENT, M_STRING
	} mode_t;

	mode_t mode_q;
	logic  dot_q;
	pos_t  cur_row_q, cur_col_q, tok_row_q, tok_col_q;

	logic [7:0] b;
	logic is_digit, is_alpha, is_space, is_ident;
	logic       pk_v;
	logic [3:0] pk;

	logic  sb_v, sb_tok, sb_clr_dot;
	res_t  sb_res;
	mode_t sb_mode;

	logic  p_v, s_v, tok_ld, nxt_dot;
	res_t  p, s;
	mode_t nxt_mode;

	assign b        = char_byte;
	assign is_digit = (b >= 8'h30) && (b <= 8'h39);
	assign is_alpha = ((b >= 8'h61) && (b <= 8'h7a)) || ((b >= 8'h41) && (b <= 8'h5a));
	assign is_space = (b == CH_SPACE) || ((b >= 8'h09) && (b <= 8'h0d));
	assign is_ident = is_alpha || is_digit || (b == CH_UNDER) || (b == CH_MINUS);

	always_comb begin
		pk_v = 1'b1;
		pk   = K_LBRACE;
		unique case (b)
			CH_LBRACE: pk = K_LBRACE;
			CH_RBRACE: pk = K_RBRACE;
			CH_COLON:  pk = K_COLON;
			CH_SEMI:   pk = K_SEMICOLON;
			CH_HASH:   pk = K_HASH;
			CH_DOT:    pk = K_DOT;
			CH_COMMA:  pk = K_COMMA;
			default:   pk_v = 1'b0;
		endcase
	end

	// byte scanned from the idle mode
	always_comb begin
		sb_v       = 1'b0;
		sb_tok     = 1'b0;
		sb_clr_dot = 1'b0;
		sb_mode    = M_IDLE;
		sb_res     = make_res(K_ERROR, 1'b1, b, 1'b1, cur_row_q, cur_col_q);
		priority if (is_space) begin
		end else if (pk_v) begin
			sb_v   = 1'b1;
			sb_res = make_res(pk, 1'b1, b, 1'b1, cur_row_q, cur_col_q);
		end else begin
			sb_tok = 1'b1;
			priority if (is_digit) begin
				sb_v       = 1'b1;
				sb_mode    = M_NUMBER;
				sb_clr_dot = 1'b1;
				sb_res     = make_res(K_NUMBER, 1'b1, b, 1'b0, cur_row_q, cur_col_q);
			end else if (b == CH_MINUS) begin
				sb_mode = M_MINUS;
			end else if (is_alpha) begin
				sb_v    = 1'b1;
				sb_mode = M_IDENT;
				sb_res  = make_res(K_IDENT, 1'b1, b, 1'b0, cur_row_q, cur_col_q);
			end else if (b == CH_QUOTE) begin
				sb_mode = M_STRING;
			end else begin
				sb_v = 1'b1;
			end
		end
	end

	always_comb begin
		p_v      = 1'b0;
		s_v      = 1'b0;
		p        = make_res(K_ERROR, 1'b1, CH_MINUS, 1'b1, tok_row_q, tok_col_q);
		s        = sb_res;
		tok_ld   = 1'b0;
		nxt_mode = mode_q;
		nxt_dot  = dot_q;
		if (kind) begin
			s_v = 1'b1;
			s   = make_res(K_EOF, 1'b0, 8'd0, 1'b1, cur_row_q, cur_col_q);
			unique case (mode_q)
				M_MINUS:  p_v = 1'b1;
				M_NUMBER: begin
					p_v = 1'b1;
					p   = make_res(K_NUMBER, 1'b0, 8'd0, 1'b1, tok_row_q, tok_col_q);
				end
				M_UNIT: begin
					p_v = 1'b1;
					p   = make_res(K_UNIT, 1'b0, 8'd0, 1'b1, tok_row_q, tok_col_q);
				end
				M_IDENT: begin
					p_v = 1'b1;
					p   = make_res(K_IDENT, 1'b0, 8'd0, 1'b1, tok_row_q, tok_col_q);
				end
				M_STRING: begin
					p_v = 1'b1;
					p   = make_res(K_STRING, 1'b0, 8'd0, 1'b1, tok_row_q, tok_col_q);
				end
				default: p_v = 1'b0;
			endcase
		end else begin
			unique case (mode_q)
				M_MINUS: begin
					p_v = 1'b1;
					if (is_digit) begin
						p        = make_res(K_NUMBER, 1'b1, CH_MINUS, 1'b0, tok_row_q, tok_col_q);
						s_v      = 1'b1;
						s        = make_res(K_NUMBER, 1'b1, b, 1'b0, tok_row_q, tok_col_q);
						nxt_mode = M_NUMBER;
						nxt_dot  = 1'b0;
					end else begin
						s_v      = sb_v;
						nxt_mode = sb_mode;
						tok_ld   = sb_tok;
						if (sb_clr_dot) nxt_dot = 1'b0;
					end
				end
				M_NUMBER: begin
					p_v = 1'b1;
					if (is_digit || ((b == CH_DOT) && !dot_q)) begin
						p = make_res(K_NUMBER, 1'b1, b, 1'b0, tok_row_q, tok_col_q);
						if (b == CH_DOT) nxt_dot = 1'b1;
					end else begin
						p = make_res(K_NUMBER, 1'b0, 8'd0, 1'b1, tok_row_q, tok_col_q);
						priority if (is_alpha) begin
							s_v      = 1'b1;
							s        = make_res(K_UNIT, 1'b1, b, 1'b0, cur_row_q, cur_col_q);
							nxt_mode = M_UNIT;
							tok_ld   = 1'b1;
						end else if (b == CH_PERCENT) begin
							s_v      = 1'b1;
							s        = make_res(K_UNIT, 1'b1, b, 1'b1, cur_row_q, cur_col_q);
							nxt_mode = M_IDLE;
						end else begin
							s_v      = sb_v;
							nxt_mode = sb_mode;
							tok_ld   = sb_tok;
							if (sb_clr_dot) nxt_dot = 1'b0;
						end
					end
				end
				M_UNIT: begin
					p_v = 1'b1;
					if (is_alpha) begin
						p = make_res(K_UNIT, 1'b1, b, 1'b0, tok_row_q, tok_col_q);
					end else begin
						p        = make_res(K_UNIT, 1'b0, 8'd0, 1'b1, tok_row_q, tok_col_q);
						s_v      = sb_v;
						nxt_mode = sb_mode;
						tok_ld   = sb_tok;
						if (sb_clr_dot) nxt_dot = 1'b0;
					end
				end
				M_IDENT: begin
					p_v = 1'b1;
					if (is_ident) begin
						p = make_res(K_IDENT, 1'b1, b, 1'b0, tok_row_q, tok_col_q);
					end else begin
						p        = make_res(K_IDENT, 1'b0, 8'd0, 1'b1, tok_row_q, tok_col_q);
						s_v      = sb_v;
						nxt_mode = sb_mode;
						tok_ld   = sb_tok;
						if (sb_clr_dot) nxt_dot = 1'b0;
					end
				end
				M_STRING: begin
					p_v = 1'b1;
					if (b == CH_QUOTE) begin
						p        = make_res(K_STRING, 1'b0, 8'd0, 1'b1, tok_row_q, tok_col_q);
						nxt_mode = M_IDLE;
					end else begin
						p = make_res(K_STRING, 1'b1, b, 1'b0, tok_row_q, tok_col_q);
					end
				end
				default: begin
					s_v      = sb_v;
					nxt_mode = sb_mode;
					tok_ld   = sb_tok;
					if (sb_clr_dot) nxt_dot = 1'b0;
				end
			endcase
		end
	end

	// pack the prefix and follow-on results, mark the final one
	always_comb begin
		q_data = '0;
		if (p_v) begin
			q_data.two = s_v;
			q_data.r0  = p;
			q_data.r1  = s;
		end else begin
			q_data.two = 1'b0;
			q_data.r0  = s;
			q_data.r1  = s;
		end
		if (q_data.two) q_data.r1.last = 1'b1;
		else q_data.r0.last = 1'b1;
		q_push = accept && (p_v || s_v);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= M_IDLE;
			dot_q     <= 1'b0;
			cur_row_q <= pos_t'(1);
			cur_col_q <= pos_t'(1);
			tok_row_q <= pos_t'(1);
			tok_col_q <= pos_t'(1);
		end else if (accept) begin
			if (kind) begin
				mode_q    <= M_IDLE;
				dot_q     <= 1'b0;
				cur_row_q <= pos_t'(1);
				cur_col_q <= pos_t'(1);
				tok_row_q <= pos_t'(1);
				tok_col_q <= pos_t'(1);
			end else begin
				mode_q <= nxt_mode;
				dot_q  <= nxt_dot;
				if (tok_ld) begin
					tok_row_q <= cur_row_q;
					tok_col_q <= cur_col_q;
				end
				// saturating position counters
				if (b == CH_NEWLINE) begin
					if (cur_row_q != '1) cur_row_q <= cur_row_q + pos_t'(1);
					cur_col_q <= pos_t'(1);
				end else if (cur_col_q != '1) begin
					cur_col_q <= cur_col_q + pos_t'(1);
				end
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/css_tok_fifo.sv =====
// ---------------------------------------------------------------------------
// css_tok_fifo
// Short queue of result pairs between the scanner and the output side.
// ---------------------------------------------------------------------------
`default_nettype none

module css_tok_fifo import css_tok_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  wr_en,
	input  wire pair_t wr_data,
	input  wire logic  rd_en,
	output logic       full,
	output logic       empty,
	output pair_t      rd_data
);

	pair_t           mem_q [Q_DEPTH];
	logic [Q_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [Q_AW:0]   count_q;

	assign full    = (count_q == (Q_AW+1)'(Q_DEPTH));
	assign empty   = (count_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) wr_ptr_q <= wr_ptr_q + Q_AW'(1);
			if (rd_en) rd_ptr_q <= rd_ptr_q + Q_AW'(1);
			if (wr_en && !rd_en) count_q <= count_q + (Q_AW+1)'(1);
			else if (rd_en && !wr_en) count_q <= count_q - (Q_AW+1)'(1);
		end
	end

endmodule

`default_nettype wire

// ===== rtl/css_tok_back.sv =====
// ---------------------------------------------------------------------------
// css_tok_back
// Walks the queued result pairs and hands out one result per transfer.
// ---------------------------------------------------------------------------
`default_nettype none

module css_tok_back import css_tok_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  q_empty,
	input  wire pair_t q_head,
	input  wire logic  pop,
	output logic       q_pop,
	output logic       empty,
	output res_t       res
);

	logic sel_q;
	logic take;

	assign empty = q_empty;
	assign res   = sel_q ? q_head.r1 : q_head.r0;
	assign take  = pop && !q_empty;
	// the pair leaves once its final result is transferred
	assign q_pop = take && (sel_q || !q_head.two);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q <= 1'b0;
		end else if (take) begin
			sel_q <= !q_pop;
		end
	end

endmodule

`default_nettype wire

// ===== sim/tb_css_token_scanner_unit.sv =====
// ---------------------------------------------------------------------------
// tb_css_token_scanner_unit
// Self-checking bench for the CSS token scanner. A short directed table,
// then random CSS-like text mixed with noise. Every token result is checked
// against a scanner model kept inside the bench or against the directed table.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_css_token_scanner_unit;
	import css_tok_pkg::*;

	localparam bit         IN_BYTE      = 1'b0;
	localparam bit         IN_END       = 1'b1;
	localparam logic [7:0] CH_TAB       = 8'h09;
	localparam logic [7:0] CH_CR        = 8'h0d;
	localparam int         RANDOM_ITEMS = 1070;
	localparam int         HOLD_CYCLES  = 300;
	localparam int         STALL_LIMIT  = 2000;
	localparam int         DRAIN_CYCLES = 24;
	localparam pos_t       POS_SAT      = '1;
	localparam res_t       NO_TOKEN     = '0;
	localparam logic [7:0] PUNCT_SET [7] = '{CH_LBRACE, CH_RBRACE, CH_COLON, CH_SEMI,
		CH_HASH, CH_DOT, CH_COMMA};

	typedef enum logic [2:0] {
		ST_IDLE, ST_MINUS, ST_NUMBER, ST_UNIT, ST_IDENT, ST_STRING
	} scan_state_t;

	typedef struct {
		bit         kind;
		logic [7:0] ch;
		bit         typed;
		res_t       want;
	} dir_row_t;

	// first result typed in where it is plain to read, the rest is predicted
	dir_row_t dir_tab [28] = '{
		'{IN_BYTE, CH_LBRACE, 1'b1, '{K_LBRACE, 1'b1, CH_LBRACE, 1'b1, 16'd1, 16'd1, 1'b1}},
		'{IN_BYTE, 8'h00, 1'b1, '{K_ERROR, 1'b1, 8'h00, 1'b1, 16'd1, 16'd2, 1'b1}},
		'{IN_BYTE, 8'hff, 1'b1, '{K_ERROR, 1'b1, 8'hff, 1'b1, 16'd1, 16'd3, 1'b1}},
		'{IN_BYTE, CH_MINUS, 1'b0, NO_TOKEN},
		'{IN_BYTE, "9", 1'b0, NO_TOKEN},
		'{IN_BYTE, CH_DOT, 1'b0, NO_TOKEN},
		'{IN_BYTE, "5", 1'b0, NO_TOKEN},
		'{IN_BYTE, CH_DOT, 1'b0, NO_TOKEN},
		'{IN_BYTE, "7", 1'b0, NO_TOKEN},
		'{IN_BYTE, CH_PERCENT, 1'b0, NO_TOKEN},
		'{IN_BYTE, "1", 1'b0, NO_TOKEN},
		'{IN_BYTE, "e", 1'b0, NO_TOKEN},
		'{IN_BYTE, CH_COLON, 1'b0, NO_TOKEN},
		'{IN_BYTE, CH_MINUS, 1'b0, NO_TOKEN},
		'{IN_BYTE, "z", 1'b1, '{K_ERROR, 1'b1, CH_MINUS, 1'b1, 16'd1, 16'd14, 1'b0}},
		'{IN_BYTE, CH_UNDER, 1'b0, NO_TOKEN},
		'{IN_BYTE, CH_QUOTE, 1'b0, NO_TOKEN},
		'{IN_BYTE, CH_NEWLINE, 1'b0, NO_TOKEN},
		'{IN_BYTE, CH_QUOTE, 1'b0, NO_TOKEN},
		'{IN_BYTE, CH_SEMI, 1'b0, NO_TOKEN},
		'{IN_BYTE, CH_HASH, 1'b0, NO_TOKEN},
		'{IN_BYTE, CH_COMMA, 1'b0, NO_TOKEN},
		'{IN_BYTE, CH_SPACE, 1'b0, NO_TOKEN},
		'{IN_BYTE, CH_MINUS, 1'b0, NO_TOKEN},
		'{IN_END, 8'h5a, 1'b1, '{K_ERROR, 1'b1, CH_MINUS, 1'b1, 16'd2, 16'd6, 1'b0}},
		'{IN_BYTE, CH_QUOTE, 1'b0, NO_TOKEN},
		'{IN_BYTE, "k", 1'b0, NO_TOKEN},
		'{IN_END, 8'ha5, 1'b0, NO_TOKEN}
	};

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       push      = 1'b0;
	logic       kind      = 1'b0;
	logic [7:0] char_byte = 8'h00;
	logic       pop       = 1'b0;
	logic       full, empty, token_done, has_text, last;
	logic [3:0] token_kind;
	logic [7:0] text_byte;
	pos_t       start_row, start_col;

	// scanner model state
	scan_state_t scan_st   = ST_IDLE;
	bit          dot_seen  = 1'b0;
	pos_t        line_no   = 1;
	pos_t        col_no    = 1;
	pos_t        tok_line  = 1;
	pos_t        tok_col   = 1;

	res_t        step_tokens [$];
	res_t        pending_tokens [$];
	logic [8:0]  text_chunk [$];
	bit          typed_on  = 1'b0;
	res_t        typed_tok = '0;
	bit          idle_on   = 1'b1;
	bit          hold_req  = 1'b0;
	int          fails     = 0;
	int          stall_cycles = 0;

	css_token_scanner_unit uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.kind       (kind),
		.char_byte  (char_byte),
		.empty      (empty),
		.pop        (pop),
		.token_kind (token_kind),
		.has_text   (has_text),
		.text_byte  (text_byte),
		.token_done (token_done),
		.start_row  (start_row),
		.start_col  (start_col),
		.last       (last)
	);

	initial forever #2 clk = ~clk;

	function automatic bit is_digit(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic bit is_alpha(logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic bit is_blank(logic [7:0] c);
		return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
	endfunction

	function automatic void add_token(logic [3:0] k, logic has, logic [7:0] c, logic done,
			pos_t r, pos_t cl);
		res_t t;
		t.kind      = k;
		t.has_text  = has;
		t.text_byte = has ? c : 8'h00;
		t.done      = done;
		t.row       = r;
		t.col       = cl;
		t.last      = 1'b0;
		step_tokens.insert(step_tokens.size(), t);
	endfunction

	function automatic void close_token(logic [3:0] k);
		scan_st = ST_IDLE;
		add_token(k, 1'b0, 8'h00, 1'b1, tok_line, tok_col);
	endfunction

	// a byte seen with no token open
	function automatic void open_token(logic [7:0] c);
		if (is_blank(c))
			return;
		case (c)
			CH_LBRACE: add_token(K_LBRACE, 1'b1, c, 1'b1, line_no, col_no);
			CH_RBRACE: add_token(K_RBRACE, 1'b1, c, 1'b1, line_no, col_no);
			CH_COLON:  add_token(K_COLON, 1'b1, c, 1'b1, line_no, col_no);
			CH_SEMI:   add_token(K_SEMICOLON, 1'b1, c, 1'b1, line_no, col_no);
			CH_HASH:   add_token(K_HASH, 1'b1, c, 1'b1, line_no, col_no);
			CH_DOT:    add_token(K_DOT, 1'b1, c, 1'b1, line_no, col_no);
			CH_COMMA:  add_token(K_COMMA, 1'b1, c, 1'b1, line_no, col_no);
			default: begin
				tok_line = line_no;
				tok_col  = col_no;
				if (is_digit(c)) begin
					scan_st  = ST_NUMBER;
					dot_seen = 1'b0;
					add_token(K_NUMBER, 1'b1, c, 1'b0, tok_line, tok_col);
				end else if (c == CH_MINUS) begin
					scan_st = ST_MINUS;
				end else if (is_alpha(c)) begin
					scan_st = ST_IDENT;
					add_token(K_IDENT, 1'b1, c, 1'b0, tok_line, tok_col);
				end else if (c == CH_QUOTE) begin
					scan_st = ST_STRING;
				end else begin
					add_token(K_ERROR, 1'b1, c, 1'b1, line_no, col_no);
				end
			end
		endcase
	endfunction

	function automatic void restart_scanner();
		scan_st  = ST_IDLE;
		dot_seen = 1'b0;
		line_no  = 1;
		col_no   = 1;
		tok_line = 1;
		tok_col  = 1;
	endfunction

	// tokens caused by one accepted transfer, left in step_tokens
	function automatic void scan_item(bit k, logic [7:0] c);
		step_tokens.delete();
		if (k == IN_END) begin
			case (scan_st)
				ST_MINUS:  add_token(K_ERROR, 1'b1, CH_MINUS, 1'b1, tok_line, tok_col);
				ST_NUMBER: close_token(K_NUMBER);
				ST_UNIT:   close_token(K_UNIT);
				ST_IDENT:  close_token(K_IDENT);
				ST_STRING: close_token(K_STRING);
				default: ;
			endcase
			add_token(K_EOF, 1'b0, 8'h00, 1'b1, line_no, col_no);
			restart_scanner();
		end else begin
			case (scan_st)
				ST_MINUS: begin
					if (is_digit(c)) begin
						add_token(K_NUMBER, 1'b1, CH_MINUS, 1'b0, tok_line, tok_col);
						add_token(K_NUMBER, 1'b1, c, 1'b0, tok_line, tok_col);
						scan_st  = ST_NUMBER;
						dot_seen = 1'b0;
					end else begin
						add_token(K_ERROR, 1'b1, CH_MINUS, 1'b1, tok_line, tok_col);
						scan_st = ST_IDLE;
						open_token(c);
					end
				end
				ST_NUMBER: begin
					if (is_digit(c) || (c == CH_DOT && !dot_seen)) begin
						if (c == CH_DOT)
							dot_seen = 1'b1;
						add_token(K_NUMBER, 1'b1, c, 1'b0, tok_line, tok_col);
					end else begin
						close_token(K_NUMBER);
						if (is_alpha(c)) begin
							scan_st  = ST_UNIT;
							tok_line = line_no;
							tok_col  = col_no;
							add_token(K_UNIT, 1'b1, c, 1'b0, tok_line, tok_col);
						end else if (c == CH_PERCENT) begin
							add_token(K_UNIT, 1'b1, c, 1'b1, line_no, col_no);
						end else begin
							open_token(c);
						end
					end
				end
				ST_UNIT: begin
					if (is_alpha(c)) begin
						add_token(K_UNIT, 1'b1, c, 1'b0, tok_line, tok_col);
					end else begin
						close_token(K_UNIT);
						open_token(c);
					end
				end
				ST_IDENT: begin
					if (is_alpha(c) || is_digit(c) || c == CH_UNDER || c == CH_MINUS) begin
						add_token(K_IDENT, 1'b1, c, 1'b0, tok_line, tok_col);
					end else begin
						close_token(K_IDENT);
						open_token(c);
					end
				end
				ST_STRING: begin
					if (c == CH_QUOTE)
						close_token(K_STRING);
					else
						add_token(K_STRING, 1'b1, c, 1'b0, tok_line, tok_col);
				end
				default: open_token(c);
			endcase
			if (c == CH_NEWLINE) begin
				if (line_no != POS_SAT)
					line_no++;
				col_no = 1;
			end else if (col_no != POS_SAT) begin
				col_no++;
			end
		end
		if (step_tokens.size() > 0)
			step_tokens[step_tokens.size() - 1].last = 1'b1;
	endfunction

	function automatic void check_field(string name, int unsigned expv, int unsigned actv);
		if (expv != actv) begin
			fails++;
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, expv, actv);
		end
	endfunction

	function automatic void check_token();
		res_t want;
		if (pending_tokens.size() == 0) begin
			fails++;
			$display("%0t: unexpected result, expected none, got kind %0d text %h",
				$time, token_kind, text_byte);
			return;
		end
		want = pending_tokens.pop_front();
		check_field("token_kind", want.kind, token_kind);
		check_field("has_text", want.has_text, has_text);
		check_field("text_byte", want.text_byte, text_byte);
		check_field("token_done", want.done, token_done);
		check_field("start_row", want.row, start_row);
		check_field("start_col", want.col, start_col);
		check_field("last", want.last, last);
	endfunction

	// both handshakes seen at the rising edge, input side first
	always @(posedge clk) begin
		if (arst_n) begin
			if (push && !full) begin
				scan_item(kind, char_byte);
				if (typed_on && step_tokens.size() > 0)
					step_tokens[0] = typed_tok;
				foreach (step_tokens[i])
					pending_tokens.insert(pending_tokens.size(), step_tokens[i]);
			end
			if (pop && !empty)
				check_token();
			if ((push && !full) || (pop && !empty))
				stall_cycles = 0;
			else
				stall_cycles++;
		end
	end

	// entered and left at a falling edge; push is written once per edge
	task automatic send_item(bit k, logic [7:0] c, bit typed, res_t want);
		int gap;
		gap = idle_on ? $urandom_range(0, 15) : 0;
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		push      <= 1'b1;
		kind      <= k;
		char_byte <= c;
		typed_on  = typed;
		typed_tok = want;
		@(posedge clk);
		while (full) @(posedge clk);
		@(negedge clk);
	endtask

	function automatic logic [7:0] pick_alpha();
		int r;
		r = $urandom_range(0, 51);
		return (r < 26) ? 8'("a" + r) : 8'("A" + r - 26);
	endfunction

	function automatic logic [7:0] pick_digit();
		return 8'("0" + $urandom_range(0, 9));
	endfunction

	function automatic void chunk_add(bit k, logic [7:0] c);
		text_chunk.insert(text_chunk.size(), {k, c});
	endfunction

	function automatic void build_chunk();
		int r;
		logic [7:0] c;
		text_chunk.delete();
		r = $urandom_range(0, 99);
		if (r < 18) begin
			chunk_add(IN_BYTE, pick_alpha());
			repeat ($urandom_range(0, 6)) begin
				case ($urandom_range(0, 5))
					0, 1: c = pick_alpha();
					2, 3: c = pick_digit();
					4: c = CH_UNDER;
					default: c = CH_MINUS;
				endcase
				chunk_add(IN_BYTE, c);
			end
		end else if (r < 40) begin
			if ($urandom_range(0, 1))
				chunk_add(IN_BYTE, CH_MINUS);
			repeat ($urandom_range(1, 4)) chunk_add(IN_BYTE, pick_digit());
			if ($urandom_range(0, 9) < 4) begin
				chunk_add(IN_BYTE, CH_DOT);
				repeat ($urandom_range(0, 3)) chunk_add(IN_BYTE, pick_digit());
			end
			// an extra dot, which ends the number when one was already taken
			if ($urandom_range(0, 9) == 0)
				chunk_add(IN_BYTE, CH_DOT);
			r = $urandom_range(0, 9);
			if (r < 3)
				repeat ($urandom_range(1, 3)) chunk_add(IN_BYTE, pick_alpha());
			else if (r < 5)
				chunk_add(IN_BYTE, CH_PERCENT);
		end else if (r < 50) begin
			chunk_add(IN_BYTE, CH_QUOTE);
			repeat ($urandom_range(0, 6)) begin
				c = 8'($urandom_range(0, 255));
				if (c == CH_QUOTE)
					c = CH_NEWLINE;
				chunk_add(IN_BYTE, c);
			end
			if ($urandom_range(0, 9) != 0)
				chunk_add(IN_BYTE, CH_QUOTE);
		end else if (r < 65) begin
			chunk_add(IN_BYTE, PUNCT_SET[$urandom_range(0, 6)]);
		end else if (r < 80) begin
			case ($urandom_range(0, 2))
				0: c = CH_SPACE;
				1: c = CH_NEWLINE;
				default: c = 8'($urandom_range(CH_TAB, CH_CR));
			endcase
			chunk_add(IN_BYTE, c);
		end else if (r < 85) begin
			chunk_add(IN_BYTE, CH_MINUS);
		end else if (r < 97) begin
			chunk_add(IN_BYTE, 8'($urandom_range(0, 255)));
		end else begin
			chunk_add(IN_END, 8'($urandom_range(0, 255)));
		end
	endfunction

	// result side
	initial begin
		int wait_n;
		wait (arst_n);
		@(negedge clk);
		forever begin
			wait_n = idle_on ? $urandom_range(0, 15) : 0;
			if (hold_req) begin
				wait_n += HOLD_CYCLES;
				hold_req = 1'b0;
			end
			if (wait_n > 0) begin
				pop <= 1'b0;
				repeat (wait_n) @(negedge clk);
			end
			pop <= 1'b1;
			@(posedge clk);
			while (empty) @(posedge clk);
			@(negedge clk);
		end
	end

	initial begin
		wait (stall_cycles >= STALL_LIMIT);
		$display("[css_token_scanner_unit] ERROR");
		$finish;
	end

	initial begin
		int  sent;
		bit  held;
		bit  drained;
		sent    = 0;
		held    = 1'b0;
		drained = 1'b0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (dir_tab[i])
			send_item(dir_tab[i].kind, dir_tab[i].ch, dir_tab[i].typed, dir_tab[i].want);

		while (sent < RANDOM_ITEMS) begin
			idle_on = !((sent >= 400 && sent < 520) || (sent >= 850 && sent < 950));
			if (!held && sent >= 250) begin
				// result side stops for a while, input keeps coming until full
				hold_req = 1'b1;
				held     = 1'b1;
			end
			if (!drained && sent >= 700) begin
				drained = 1'b1;
				push <= 1'b0;
				do @(negedge clk); while (pending_tokens.size() != 0);
			end
			build_chunk();
			foreach (text_chunk[i])
				send_item(text_chunk[i][8], text_chunk[i][7:0], 1'b0, NO_TOKEN);
			sent += text_chunk.size();
		end

		// close out whatever the random text left open
		idle_on = 1'b1;
		send_item(IN_BYTE, CH_RBRACE, 1'b0, NO_TOKEN);
		send_item(IN_END, 8'hff, 1'b0, NO_TOKEN);

		push <= 1'b0;
		while (pending_tokens.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fails == 0)
			$display("[css_token_scanner_unit] OK");
		else
			$display("[css_token_scanner_unit] ERROR");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/css_tok_pkg.sv
rtl/css_tok_front.sv
rtl/css_tok_fifo.sv
rtl/css_tok_back.sv
rtl/css_token_scanner_unit.sv
sim/tb_css_token_scanner_unit.sv
